// ===== design/base64_codec_defines.svh =====
// assertion helpers shared by the codec modules
`ifndef BASE64_CODEC_DEFINES_SVH
`define BASE64_CODEC_DEFINES_SVH

// same-cycle implication, checked outside reset
`define B64_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 codec check failed");

// next-cycle implication, checked outside reset
`define B64_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 codec check failed");

`endif

// ===== design/b64_pkg.sv =====
`default_nettype none

package b64_pkg;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [0:0] REG_MODE = 1'b0;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    JOB_ENC = 2'd0,
    JOB_DEC = 2'd1,
    JOB_ERR = 2'd2
  } job_kind_t;

  // one finished group handed from front to back
  // cnt: encode -> chars taken from data minus one, decode -> bytes minus one
  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] bits;
    logic [1:0]  cnt;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] s8;
    logic [7:0] c;
    s8 = {2'b00, s};
    if (s8 < 8'd26) begin
      c = CHAR_UC_A + s8;
    end else if (s8 < 8'd52) begin
      c = CHAR_LC_A + s8 - 8'd26;
    end else if (s8 < 8'd62) begin
      c = CHAR_ZERO + s8 - 8'd52;
    end else if (s8 == 8'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] t;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      t = c - CHAR_UC_A;
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      t = c - CHAR_LC_A + 8'd26;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO + 8'd52;
    end else if (c == CHAR_PLUS) begin
      t = 8'd62;
    end else if (c == CHAR_SLASH) begin
      t = 8'd63;
    end else begin
      t = 8'd0;
    end
    return t[5:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/base64_codec.sv =====
// base64 codec, standard alphabet with '=' padding
// input channel (in_valid / in_stall): one byte or character per beat, in_last
// closes the stream. result channel (out_valid / out_stall): one character or
// byte per beat, out_last on the final beat of the stream, out_length_error on
// the single beat that ends a decode stream of bad length.
// mode is set over the apb port at address 0 (0 encode, 1 decode); a write
// restarts the group; the user must make it only while the block is idle,
// as the block itself does not enforce it. a beat that completes a group is
// written into the group queue, and its first result is then loaded into the
// result register, which sends one beat per cycle while the receiver does not
// stall; a two-entry group queue lets input keep flowing while results
// drain. when the receiver stalls, the result register holds its beat, the
// queue fills and in_stall rises once both entries are taken.
// reset clears mode to encode and empties the group and the queue.
`default_nettype none

module base64_codec import b64_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_length_error
);

  logic       mode_r, mode_nxt;
  logic       cfg_wr;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head;
  fifo_stat_t q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_MODE) && (cfg_paddr[1:0] == 2'b00);
  assign mode_nxt   = cfg_wr ? cfg_pwdata[0] : mode_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODE) ? {31'b0, mode_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  b64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .clear    (cfg_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  b64_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  b64_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_length_error (out_length_error)
  );

endmodule

`default_nettype wire

// ===== design/b64_front.sv =====
`default_nettype none
`include "base64_codec_defines.svh"

module b64_front import b64_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       mode,
  input  wire logic       clear,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire fifo_stat_t q_stat,
  output logic            push,
  output job_t            push_job
);

  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        twp_r, twp_nxt;

  logic        accept;
  logic [4:0]  enc_shift;
  logic [4:0]  dec_shift;
  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic [1:0]  enc_filled;
  logic        is_pad;
  logic [5:0]  sextet;
  logic [1:0]  drop;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    unique case (cnt_r)
      2'd0:    enc_shift = 5'd16;
      2'd1:    enc_shift = 5'd8;
      default: enc_shift = 5'd0;
    endcase
    unique case (cnt_r)
      2'd0:    dec_shift = 5'd18;
      2'd1:    dec_shift = 5'd12;
      2'd2:    dec_shift = 5'd6;
      default: dec_shift = 5'd0;
    endcase
    enc_bits   = bits_r | ({16'b0, in_byte} << enc_shift);
    enc_filled = (cnt_r >= 2'd2) ? 2'd3 : cnt_r + 2'd1;
    is_pad     = (in_byte == CHAR_PAD);
    sextet     = is_pad ? 6'd0 : char_to_sextet(in_byte);
    dec_bits   = bits_r | ({18'b0, sextet} << dec_shift);
    drop       = in_last ? ({1'b0, is_pad} + {1'b0, twp_r}) : 2'd0;
  end

  always_comb begin
    push          = 1'b0;
    push_job      = '0;
    push_job.kind = JOB_ENC;
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    twp_nxt       = twp_r;
    if (clear) begin
      bits_nxt = '0;
      cnt_nxt  = '0;
      twp_nxt  = 1'b0;
    end else if (accept) begin
      if (mode == MODE_ENCODE) begin
        if (enc_filled == 2'd3 || in_last) begin
          push          = 1'b1;
          push_job.kind = JOB_ENC;
          push_job.bits = enc_bits;
          push_job.cnt  = enc_filled;
          push_job.last = in_last;
          bits_nxt      = '0;
          cnt_nxt       = '0;
          twp_nxt       = 1'b0;
        end else begin
          bits_nxt = enc_bits;
          cnt_nxt  = enc_filled;
        end
      end else begin
        if (cnt_r == 2'd3) begin
          push          = 1'b1;
          push_job.kind = JOB_DEC;
          push_job.bits = dec_bits;
          push_job.cnt  = 2'd2 - drop;
          push_job.last = in_last;
          bits_nxt      = '0;
          cnt_nxt       = '0;
          twp_nxt       = 1'b0;
        end else if (in_last) begin
          // stream ended inside a group
          push          = 1'b1;
          push_job.kind = JOB_ERR;
          push_job.last = 1'b1;
          bits_nxt      = '0;
          cnt_nxt       = '0;
          twp_nxt       = 1'b0;
        end else begin
          bits_nxt = dec_bits;
          cnt_nxt  = cnt_r + 2'd1;
          if (cnt_r == 2'd0) begin
            twp_nxt = 1'b0;
          end else if (cnt_r == 2'd2) begin
            twp_nxt = is_pad;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      cnt_r  <= '0;
      twp_r  <= 1'b0;
    end else begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
      twp_r  <= twp_nxt;
    end
  end

  `B64_ASSERT_NEXT(a_push_clears_group, push, cnt_r == 2'd0 && bits_r == 24'd0)

endmodule

`default_nettype wire

// ===== design/b64_fifo.sv =====
`default_nettype none
`include "base64_codec_defines.svh"

module b64_fifo import b64_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output fifo_stat_t stat
);

  job_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `B64_ASSERT_NOW(a_no_overflow, push, !stat.full)
  `B64_ASSERT_NOW(a_no_underflow, pop, !stat.empty)

endmodule

`default_nettype wire

// ===== design/b64_back.sv =====
`default_nettype none
`include "base64_codec_defines.svh"

module b64_back import b64_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head,
  input  wire fifo_stat_t q_stat,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_length_error
);

  logic       valid_r, valid_nxt;
  logic [1:0] k_r, k_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       err_r;

  logic       load;
  logic       final_beat;
  logic [7:0] res_byte;
  logic       res_last;
  logic       res_err;
  logic [5:0] sextet;

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_last         = last_r;
  assign out_length_error = err_r;

  always_comb begin
    unique case (k_r)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      default: sextet = head.bits[5:0];
    endcase
  end

  // build the beat at index k_r of the head job
  always_comb begin
    res_byte   = 8'd0;
    res_last   = 1'b0;
    res_err    = 1'b0;
    final_beat = 1'b1;
    unique case (head.kind)
      JOB_ENC: begin
        res_byte   = (k_r <= head.cnt) ? sextet_to_char(sextet) : CHAR_PAD;
        final_beat = (k_r == 2'd3);
        res_last   = head.last && final_beat;
      end
      JOB_DEC: begin
        unique case (k_r)
          2'd0:    res_byte = head.bits[23:16];
          2'd1:    res_byte = head.bits[15:8];
          default: res_byte = head.bits[7:0];
        endcase
        final_beat = (k_r == head.cnt);
        res_last   = head.last && final_beat;
      end
      JOB_ERR: begin
        res_last = 1'b1;
        res_err  = 1'b1;
      end
      default: begin
        final_beat = 1'b1;
      end
    endcase
  end

  assign load = !q_stat.empty && (!valid_r || !out_stall);
  assign pop  = load && final_beat;

  always_comb begin
    valid_nxt = valid_r;
    k_nxt     = k_r;
    if (load) begin
      valid_nxt = 1'b1;
      k_nxt     = final_beat ? 2'd0 : k_r + 2'd1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= '0;
    end else begin
      valid_r <= valid_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= res_byte;
      last_r <= res_last;
      err_r  <= res_err;
    end
  end

  `B64_ASSERT_NOW(a_err_is_last, valid_r && err_r, last_r && byte_r == 8'd0)

endmodule

`default_nettype wire

// ===== tb/base64_codec_check.sv =====
`timescale 1ns / 1ps

module base64_codec_check
  import b64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        out_length_error,
  output int          mismatches,
  output int          beats_due
);

  localparam logic [2:0] ADDR_MODE = {REG_MODE, 2'b00};
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       len_err;
  } codec_beat_t;

  codec_beat_t due_q[$];

  logic        cur_mode = MODE_ENCODE;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_fill = '0;
  logic        grp_pad3 = 1'b0;
  int          miss_count = 0;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    if (s < 6'd26) return CHAR_UC_A + 8'(s);
    if (s < 6'd52) return CHAR_LC_A + 8'(s) - 8'd26;
    if (s < 6'd62) return CHAR_ZERO + 8'(s) - 8'd52;
    return (s == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
  endfunction

  // anything outside the alphabet counts as zero
  function automatic logic [5:0] char_sextet(input logic [7:0] c);
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return 6'(c - CHAR_UC_A);
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return 6'(c - CHAR_LC_A + 8'd26);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return 6'(c - CHAR_ZERO + 8'd52);
    if (c == CHAR_PLUS) return 6'd62;
    if (c == CHAR_SLASH) return 6'd63;
    return 6'd0;
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    miss_count++;
    if (miss_count <= PRINT_CAP)
      $display("@%0t %s mismatch: got %02h, expected %02h", $time, what, got, want);
  endtask

  task automatic restart_group();
    grp_bits = '0;
    grp_fill = '0;
    grp_pad3 = 1'b0;
  endtask

  task automatic codec_step(input logic [7:0] b, input logic close);
    logic       is_pad;
    logic [5:0] s;
    int         n;
    if (cur_mode == MODE_ENCODE) begin
      grp_bits = grp_bits | ({16'b0, b} << (16 - 8 * grp_fill));
      if (grp_fill == 2'd2 || close) begin
        n = grp_fill + 2;
        for (int k = 0; k < 4; k++)
          due_q.push_back('{(k < n) ? sextet_char(grp_bits[23 - 6 * k -: 6]) : CHAR_PAD,
                            close && k == 3, 1'b0});
        restart_group();
      end else begin
        grp_fill = grp_fill + 2'd1;
      end
    end else begin
      is_pad = (b == CHAR_PAD);
      s = is_pad ? 6'd0 : char_sextet(b);
      if (grp_fill == 2'd0) grp_pad3 = 1'b0;
      grp_bits = grp_bits | ({18'b0, s} << (18 - 6 * grp_fill));
      if (grp_fill == 2'd2) grp_pad3 = is_pad;
      if (grp_fill == 2'd3) begin
        // pads only trim bytes in the closing group
        n = 3;
        if (close) n = n - int'(is_pad) - int'(grp_pad3);
        for (int k = 0; k < n; k++)
          due_q.push_back('{grp_bits[23 - 8 * k -: 8], close && k == n - 1, 1'b0});
        restart_group();
      end else if (close) begin
        due_q.push_back('{8'h00, 1'b1, 1'b1});
        restart_group();
      end else begin
        grp_fill = grp_fill + 2'd1;
      end
    end
  endtask

  always @(posedge clk) begin
    codec_beat_t want;
    if (!rst_n) begin
      cur_mode = MODE_ENCODE;
      restart_group();
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          report("unexpected beat", out_byte, 8'h00);
        end else begin
          want = due_q.pop_front();
          if (out_byte !== want.data) report("out_byte", out_byte, want.data);
          if (out_last !== want.last) report("out_last", 8'(out_last), 8'(want.last));
          if (out_length_error !== want.len_err)
            report("out_length_error", 8'(out_length_error), 8'(want.len_err));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == ADDR_MODE) begin
        if (cfg_pwrite) begin
          cur_mode = cfg_pwdata[0];
          restart_group();
        end else if (cfg_prdata !== {31'b0, cur_mode}) begin
          report("mode readback", cfg_prdata[7:0], 8'(cur_mode));
        end
      end
      if (in_valid && !in_stall) codec_step(in_byte, in_last);
    end
    mismatches <= miss_count;
    beats_due <= due_q.size();
  end

endmodule

// ===== tb/base64_codec_test.sv =====
`timescale 1ns / 1ps

module base64_codec_test;
  import b64_pkg::*;

  localparam logic [2:0] ADDR_MODE   = {REG_MODE, 2'b00};
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int RANDOM_ITEMS  = 70;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_length_error;
  int          mismatches;
  int          beats_due;

  int sent = 0;
  int burst_left = 1;
  bit gaps_on = 1'b1;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_tick = 0;
  int stall_style = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  base64_codec u_dut (.*);

  base64_codec_check u_check (.*);

  // receiver: a stall pattern picked at random from four styles, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= (stall_tick % 8 < 3);
      endcase
    end
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 63) stall_style <= $urandom_range(0, 3);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("base64_codec_test: errors");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic close);
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= close;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], close && i == s.len() - 1);
  endtask

  task automatic cfg_access(input logic [2:0] addr, input logic wr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic cfg_idle();
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // let every due beat come out, then give a group still in flight time to finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    cfg_access(ADDR_MODE, 1'b1, {31'($urandom), m});
    cfg_access(ADDR_MODE, 1'b0, $urandom);
    cfg_idle();
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 3))
      0: return 8'(CHAR_UC_A + $urandom_range(0, 25));
      1: return 8'(CHAR_LC_A + $urandom_range(0, 25));
      2: return 8'(CHAR_ZERO + $urandom_range(0, 9));
      default: return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0: return pick_char();
      1: return CHAR_PAD;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic enc_stream(input int n, input logic close);
    for (int i = 0; i < n; i++) send_beat(8'($urandom), close && i == n - 1);
  endtask

  // well-formed text: whole groups, pads only at the tail
  task automatic dec_stream(input int groups, input int pads, input logic close);
    logic [7:0] ch;
    for (int g = 0; g < groups; g++)
      for (int p = 0; p < 4; p++) begin
        ch = (g == groups - 1 && p >= 4 - pads) ? CHAR_PAD : pick_char();
        send_beat(ch, close && g == groups - 1 && p == 3);
      end
  endtask

  task automatic noise_stream(input int n, input logic close);
    for (int i = 0; i < n; i++) send_beat(noise_char(), close && i == n - 1);
  endtask

  initial begin
    logic mode_now;
    int   n_streams;
    bit   leave_open;
    int   base;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // encode straight out of reset: full group, one byte, two bytes
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFB, 1'b0);
    send_beat(8'hEF, 1'b1);

    set_mode(MODE_DECODE);
    // pad mid stream, chars outside the alphabet, a full closing group, then padded and short streams
    send_text("A=z0", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat("~", 1'b0);
    send_beat("Z", 1'b0);
    send_text("9a+/", 1'b1);
    send_text("Yw==", 1'b1);
    send_text("Za=9", 1'b1);
    send_text("Q", 1'b1);

    // unmapped register: must leave mode alone
    drain();
    cfg_access(ADDR_UNUSED, 1'b1, $urandom);
    cfg_access(ADDR_MODE, 1'b0, $urandom);
    cfg_idle();

    // receiver holds off while the sender keeps pushing, so the input backs up
    set_mode(MODE_ENCODE);
    gaps_on = 1'b0;
    hold_asks <= hold_asks + 1;
    enc_stream(30, 1'b1);

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      mode_now = $urandom_range(0, 1) ? MODE_DECODE : MODE_ENCODE;
      set_mode(mode_now);
      gaps_on = ($urandom_range(0, 3) != 0);
      n_streams = $urandom_range(1, 3);
      for (int s = 0; s < n_streams; s++) begin
        // an unfinished stream is cut off by the next mode write
        leave_open = (s == n_streams - 1) && ($urandom_range(0, 5) == 0);
        if (mode_now == MODE_ENCODE)
          enc_stream($urandom_range(1, 10), !leave_open);
        else if ($urandom_range(0, 3) != 0)
          dec_stream($urandom_range(1, 3), $urandom_range(0, 2), !leave_open);
        else
          noise_stream($urandom_range(1, 9), !leave_open);
      end
    end

    drain();
    if (mismatches == 0 && beats_due == 0) begin
      $display("base64_codec_test: clean");
    end else begin
      $display("base64_codec_test: errors");
    end
    $finish;
  end

endmodule
